[design/adrc_pkg.sv]
// Shared types, register indexes and saturation helpers for the audio
// dynamics and reverb chain. No dependencies.
`default_nettype none
package adrc_pkg;

  localparam int unsigned VW = 20;  // working value width, covers gain and compressor growth
  localparam int unsigned DW = 18;  // delay word width

  localparam logic [2:0] REG_MASTER_GAIN = 3'd0;
  localparam logic [2:0] REG_COMP_ON     = 3'd1;
  localparam logic [2:0] REG_COMP_KNEE   = 3'd2;
  localparam logic [2:0] REG_COMP_SLOPE  = 3'd3;
  localparam logic [2:0] REG_LIM_ON      = 3'd4;
  localparam logic [2:0] REG_LIM_CEIL    = 3'd5;
  localparam logic [2:0] REG_REVERB_MIX  = 3'd6;

  localparam logic [14:0] FB_SHORT  = 15'd9830;
  localparam logic [14:0] FB_MID    = 15'd8192;
  localparam logic [14:0] FB_LONG   = 15'd6554;
  localparam logic [13:0] WET_SCALE = 14'd10813;

  typedef struct packed {
    logic signed [15:0] in_sample;
    logic               block_end;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_sample;
    logic               clipped;
    logic               block_last;
  } out_t;

  typedef struct packed {
    logic [15:0] master_gain;
    logic        compressor_on;
    logic [14:0] compressor_knee;
    logic [15:0] compressor_slope;
    logic        limiter_on;
    logic [14:0] limiter_ceiling;
    logic [15:0] reverb_mix;
  } cfg_t;

  typedef struct packed {
    logic signed [VW-1:0] v;
    logic                 last;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic signed [DW-1:0] sat18(input logic signed [21:0] a);
    if (a > 22'sd131071) return 18'sd131071;
    if (a < -22'sd131072) return -18'sd131072;
    return a[DW-1:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [21:0] a);
    if (a > 22'sd32767) return 16'sd32767;
    if (a < -22'sd32768) return -16'sd32768;
    return a[15:0];
  endfunction

endpackage
`default_nettype wire

[design/adrc_front.sv]
// Front end: accepts samples, applies gain, compressor and limiter.
// Depends on adrc_pkg.
`default_nettype none
module adrc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire adrc_pkg::cfg_t  cfg,
  input  wire logic            clear_busy,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire adrc_pkg::in_t   in_data,
  input  wire adrc_pkg::qstat_t qstat,
  output logic                 push,
  output adrc_pkg::work_t      push_data
);
  typedef enum logic [1:0] {F_IDLE, F_GAIN, F_COMP, F_LIM} fstate_t;
  fstate_t st;

  logic signed [15:0] x;
  logic               last;
  logic signed [17:0] gv;
  logic [17:0]        mag;
  logic               neg;
  logic               over;
  logic [33:0]        cp;

  logic signed [32:0] gp;
  logic [17:0]        gmag;
  logic [18:0]        m2;
  logic signed [adrc_pkg::VW-1:0] vs, c, vl;

  assign in_ready = (st == F_IDLE) && !clear_busy;
  assign gp   = x * $signed({1'b0, cfg.master_gain});
  assign gmag = gv[17] ? 18'(-gv) : 18'(gv);

  always_comb begin
    m2 = over ? (19'(cfg.compressor_knee) + 19'((cp + 34'd16384) >> 15)) : 19'(mag);
    vs = neg ? -$signed({1'b0, m2}) : $signed({1'b0, m2});
    c  = $signed({5'b0, cfg.limiter_ceiling});
    vl = vs;
    if (cfg.limiter_on) begin
      if (vs > c) vl = c;
      else if (vs < -c) vl = -c;
    end
  end

  assign push = (st == F_LIM) && !qstat.full;
  assign push_data = '{v: vl, last: last};

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= F_IDLE;
    end else begin
      case (st)
        F_IDLE: if (in_valid && in_ready) begin
          x    <= in_data.in_sample;
          last <= in_data.block_end;
          st   <= F_GAIN;
        end
        F_GAIN: begin
          gv <= 18'((gp + 33'sd16384) >>> 15);
          st <= F_COMP;
        end
        F_COMP: begin
          mag  <= gmag;
          neg  <= gv[17];
          over <= cfg.compressor_on && (gmag > 18'(cfg.compressor_knee));
          cp   <= (gmag - 18'(cfg.compressor_knee)) * cfg.compressor_slope;
          st   <= F_LIM;
        end
        F_LIM: if (!qstat.full) st <= F_IDLE;
        default: st <= F_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[design/adrc_queue.sv]
// Two-entry show-ahead queue between front and back.
// Depends on adrc_pkg.
`default_nettype none
module adrc_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire adrc_pkg::work_t  push_data,
  input  wire logic             pop,
  output adrc_pkg::work_t       head,
  output adrc_pkg::qstat_t      qstat
);
  adrc_pkg::work_t slots [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign head = slots[rp];
  assign qstat.full  = (cnt == 2'd2);
  assign qstat.empty = (cnt == 2'd0);

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

[design/adrc_back.sv]
// Back end: three feedback comb lines, wet mix, output saturation and
// output register. Clears the delay memories after reset. Depends on adrc_pkg.
`default_nettype none
module adrc_back #(
  parameter int unsigned SHORT_LEN = 4800,
  parameter int unsigned MID_LEN   = 7200,
  parameter int unsigned LONG_LEN  = 9600
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire adrc_pkg::cfg_t   cfg,
  input  wire adrc_pkg::qstat_t qstat,
  input  wire adrc_pkg::work_t  head,
  output logic                  pop,
  output logic                  clear_busy,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output adrc_pkg::out_t        out_data
);
  localparam int unsigned SW = $clog2(SHORT_LEN);
  localparam int unsigned MW = $clog2(MID_LEN);
  localparam int unsigned LW = $clog2(LONG_LEN);
  localparam int unsigned ML = (SHORT_LEN > MID_LEN) ?
    ((SHORT_LEN > LONG_LEN) ? SHORT_LEN : LONG_LEN) :
    ((MID_LEN > LONG_LEN) ? MID_LEN : LONG_LEN);
  localparam int unsigned CW = $clog2(ML);
  localparam int unsigned DW = adrc_pkg::DW;
  localparam int unsigned VW = adrc_pkg::VW;

  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_FB, B_WR, B_MIX} bstate_t;
  bstate_t st;

  logic signed [DW-1:0] mem_s [SHORT_LEN];
  logic signed [DW-1:0] mem_m [MID_LEN];
  logic signed [DW-1:0] mem_l [LONG_LEN];
  logic signed [DW-1:0] rd_s, rd_m, rd_l;
  logic [SW-1:0] pos_s;
  logic [MW-1:0] pos_m;
  logic [LW-1:0] pos_l;
  logic [CW-1:0] clr_cnt;

  logic signed [VW-1:0] v;
  logic                 last, rev;
  logic signed [33:0]   fp_s, fp_m, fp_l;
  logic signed [19:0]   dsum;
  logic signed [50:0]   wp;
  logic [29:0]          kmix;

  logic clearing, wr;
  logic signed [DW-1:0] wd_s, wd_m, wd_l;
  logic signed [50:0]   wet;
  logic signed [21:0]   fin;
  logic signed [15:0]   fin16;

  assign clearing   = (st == B_CLEAR);
  assign clear_busy = clearing;
  assign wr  = (st == B_WR);
  assign pop = (st == B_IDLE) && !qstat.empty;

  assign wd_s = clearing ? '0 : adrc_pkg::sat18(22'(v) + 22'((fp_s + 34'sd16384) >>> 15));
  assign wd_m = clearing ? '0 : adrc_pkg::sat18(22'(v) + 22'((fp_m + 34'sd16384) >>> 15));
  assign wd_l = clearing ? '0 : adrc_pkg::sat18(22'(v) + 22'((fp_l + 34'sd16384) >>> 15));

  assign wet   = rev ? ((wp + 51'sd536870912) >>> 30) : '0;
  assign fin   = 22'(v) + 22'(wet);
  assign fin16 = adrc_pkg::sat16(fin);

  always_ff @(posedge clk) begin
    if ((clearing && (32'(clr_cnt) < SHORT_LEN)) || wr)
      mem_s[clearing ? clr_cnt[SW-1:0] : pos_s] <= wd_s;
    rd_s <= mem_s[pos_s];
  end
  always_ff @(posedge clk) begin
    if ((clearing && (32'(clr_cnt) < MID_LEN)) || wr)
      mem_m[clearing ? clr_cnt[MW-1:0] : pos_m] <= wd_m;
    rd_m <= mem_m[pos_m];
  end
  always_ff @(posedge clk) begin
    if ((clearing && (32'(clr_cnt) < LONG_LEN)) || wr)
      mem_l[clearing ? clr_cnt[LW-1:0] : pos_l] <= wd_l;
    rd_l <= mem_l[pos_l];
  end

  always_ff @(posedge clk) begin
    kmix <= cfg.reverb_mix * adrc_pkg::WET_SCALE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= B_CLEAR;
      clr_cnt <= '0;
      pos_s <= '0;
      pos_m <= '0;
      pos_l <= '0;
      out_valid <= 1'b0;
    end else begin
      // B_MIX reloads the output register itself
      if (out_valid && out_ready && (st != B_MIX)) out_valid <= 1'b0;
      case (st)
        B_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CW'(ML - 1)) st <= B_IDLE;
        end
        B_IDLE: if (!qstat.empty) begin
          v    <= head.v;
          last <= head.last;
          rev  <= (cfg.reverb_mix != 16'd0);
          st   <= (cfg.reverb_mix != 16'd0) ? B_FB : B_MIX;
        end
        B_FB: begin
          fp_s <= rd_s * $signed({1'b0, adrc_pkg::FB_SHORT});
          fp_m <= rd_m * $signed({1'b0, adrc_pkg::FB_MID});
          fp_l <= rd_l * $signed({1'b0, adrc_pkg::FB_LONG});
          dsum <= 20'(rd_s) + 20'(rd_m) + 20'(rd_l);
          st   <= B_WR;
        end
        B_WR: begin
          wp <= dsum * $signed({1'b0, kmix});
          pos_s <= (pos_s == SW'(SHORT_LEN - 1)) ? '0 : pos_s + 1'b1;
          pos_m <= (pos_m == MW'(MID_LEN - 1)) ? '0 : pos_m + 1'b1;
          pos_l <= (pos_l == LW'(LONG_LEN - 1)) ? '0 : pos_l + 1'b1;
          st <= B_MIX;
        end
        B_MIX: if (!out_valid || out_ready) begin
          out_data.out_sample <= fin16;
          out_data.clipped    <= (22'(fin16) != fin);
          out_data.block_last <= last;
          out_valid <= 1'b1;
          st <= B_IDLE;
        end
        default: st <= B_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[design/audio_dynamics_reverb_chain_top.sv]
// Top level of the audio dynamics and reverb chain: configuration registers,
// front end, queue and back end. Depends on adrc_pkg and the adrc_* modules.
`default_nettype none
// One signed Q1.15 sample per transfer goes through master gain, optional
// compressor, optional limiter and, when reverb_mix is nonzero, three feedback
// comb lines (gains 0.3, 0.25, 0.2) mixed back at reverb_mix * 0.33; the result
// is saturated to 16 bits with a clip flag. The front end takes a new sample
// only once the last is pushed (accept, gain multiply, compressor multiply,
// limiter and queue push, which waits while the queue is full); the back end
// steps through memory read, feedback multiply, write-back with wet multiply
// and mix with reverb, and only the mix without. A two-entry queue parts the
// two, and the output register lets new samples enter while a result waits.
// After reset a clearing pass zeroes the delay memories, one address per
// cycle over max(SHORT_LEN, MID_LEN, LONG_LEN) addresses (9600 by default);
// no sample is taken meanwhile, configuration writes are.
module audio_dynamics_reverb_chain_top #(
  parameter int unsigned SHORT_LEN = 4800,
  parameter int unsigned MID_LEN   = 7200,
  parameter int unsigned LONG_LEN  = 9600
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire adrc_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output adrc_pkg::out_t      out_data,
  input  wire logic           cfg_we,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [15:0]    cfg_data
);
  adrc_pkg::cfg_t   cfg;
  adrc_pkg::qstat_t qstat;
  adrc_pkg::work_t  push_data, head;
  logic push, pop, clear_busy;

  // register file; unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.master_gain      <= 16'd32768;
      cfg.compressor_on    <= 1'b0;
      cfg.compressor_knee  <= 15'd8231;
      cfg.compressor_slope <= 16'd8192;
      cfg.limiter_on       <= 1'b1;
      cfg.limiter_ceiling  <= 15'd32393;
      cfg.reverb_mix       <= 16'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        adrc_pkg::REG_MASTER_GAIN: cfg.master_gain      <= cfg_data;
        adrc_pkg::REG_COMP_ON:     cfg.compressor_on    <= cfg_data[0];
        adrc_pkg::REG_COMP_KNEE:   cfg.compressor_knee  <= cfg_data[14:0];
        adrc_pkg::REG_COMP_SLOPE:  cfg.compressor_slope <= cfg_data;
        adrc_pkg::REG_LIM_ON:      cfg.limiter_on       <= cfg_data[0];
        adrc_pkg::REG_LIM_CEIL:    cfg.limiter_ceiling  <= cfg_data[14:0];
        adrc_pkg::REG_REVERB_MIX:  cfg.reverb_mix       <= cfg_data;
        default: ;
      endcase
    end
  end

  adrc_front u_front (
    .clk, .rst, .cfg, .clear_busy, .in_valid, .in_ready, .in_data,
    .qstat, .push, .push_data
  );

  adrc_queue u_queue (
    .clk, .rst, .push, .push_data, .pop, .head, .qstat
  );

  adrc_back #(
    .SHORT_LEN(SHORT_LEN), .MID_LEN(MID_LEN), .LONG_LEN(LONG_LEN)
  ) u_back (
    .clk, .rst, .cfg, .qstat, .head, .pop, .clear_busy,
    .out_valid, .out_ready, .out_data
  );

  // no sample enters while memories are being cleared
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> !in_ready) else $error("sample accepted during clear");
  // no result can exist while clearing
  a_no_out_clear: assert property (@(posedge clk) disable iff (rst)
    clear_busy |-> !out_valid) else $error("result during clear");
  // queue never written full or read empty
  a_queue_bounds: assert property (@(posedge clk) disable iff (rst)
    !(push && qstat.full) && !(pop && qstat.empty)) else $error("queue misuse");
endmodule
`default_nettype wire
